// File: rtl/ipfrt_pkg.sv
package ipfrt_pkg;

  // Operation codes carried by a request transaction.
  typedef enum logic [1:0] {
    OP_CHECK  = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2
  } op_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  // One stored rule, held as a single word of the rule memory.
  typedef struct packed {
    logic [31:0] address;
    logic [31:0] mask;
    logic        allow;
    logic        enabled;
    logic [31:0] expiry;
  } rule_t;

  localparam int unsigned RuleW  = $bits(rule_t);
  localparam int unsigned CountW = 5;

endpackage

// File: rtl/ipfrt_ram.sv
module ipfrt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/ip_filter_rule_table.sv
// Channel   | Valid        | Ready        | Payload
// ----------+--------------+--------------+-----------------------------------------------
// request   | in_valid_i   | in_ready_o   | operation_i, ip_address_i, rule_mask_i,
//           |              |              | rule_allow_i, rule_enabled_i, rule_expires_i,
//           |              |              | now_seconds_i
// response  | out_valid_o  | out_ready_i  | allowed_o, matched_o, status_o, rule_count_o
//
// An add, or an unused operation code, goes from acceptance straight to the done state,
// which loads the response register. A check or a remove walks the rule memory one entry
// per cycle through its single read port, then passes through the done state; a check
// stops at its first hit. A new request is accepted only while the sequencer is idle.
// Reset clears the rule count and the control state; the rule memory is not cleared.
// A response that waits in the output register does not block the next request; only a
// second finished response that finds the output register still full holds the sequencer.
module ip_filter_rule_table #(
  parameter int unsigned MAX_RULES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [31:0] ip_address_i,
  input  logic [31:0] rule_mask_i,
  input  logic        rule_allow_i,
  input  logic        rule_enabled_i,
  input  logic [31:0] rule_expires_i,
  input  logic [31:0] now_seconds_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        allowed_o,
  output logic        matched_o,
  output logic        status_o,
  output logic [4:0]  rule_count_o
);

  // Index width addresses the rule memory; the count width can also hold MAX_RULES.
  localparam int unsigned IdxW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int unsigned CntW = $clog2(MAX_RULES + 1);

  ipfrt_pkg::state_e state_q, state_d;
  ipfrt_pkg::op_e    op_q, op_d;

  logic [31:0]     addr_q, addr_d;
  logic [31:0]     now_q, now_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] wr_ptr_q, wr_ptr_d;
  logic            pend_q, pend_d;

  logic res_allow_q, res_allow_d;
  logic res_match_q, res_match_d;
  logic res_status_q, res_status_d;

  logic                          out_valid_q, out_valid_d;
  logic                          out_allowed_q, out_allowed_d;
  logic                          out_matched_q, out_matched_d;
  logic                          out_status_q, out_status_d;
  logic [ipfrt_pkg::CountW-1:0]  out_count_q, out_count_d;

  logic                        ram_we;
  logic [IdxW-1:0]             ram_waddr;
  ipfrt_pkg::rule_t            ram_wdata;
  logic                        ram_re;
  logic [IdxW-1:0]             ram_raddr;
  logic [ipfrt_pkg::RuleW-1:0] ram_rdata;

  ipfrt_pkg::rule_t rd_rule;
  logic             in_fire;
  logic             out_free;
  logic             scan_end;
  logic             table_full;
  logic             rule_hit;
  logic             rule_live;
  logic             rule_keep;

  // All five rule fields live side by side in one memory word.
  ipfrt_ram #(
    .Width (ipfrt_pkg::RuleW),
    .Depth (MAX_RULES)
  ) u_rule_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_rule    = ipfrt_pkg::rule_t'(ram_rdata);
  assign in_ready_o = (state_q == ipfrt_pkg::S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // The scan has issued its last read once the read pointer reaches the count. The data of
  // that read is still in flight in the same cycle and is evaluated before the scan ends.
  assign scan_end   = (rd_ptr_q == count_q);
  assign table_full = (count_q == CntW'(MAX_RULES));

  // A zero mask asks for an exact address; otherwise only the masked bits are compared.
  assign rule_hit  = (rd_rule.mask != 32'd0) ?
                     ((addr_q & rd_rule.mask) == (rd_rule.address & rd_rule.mask)) :
                     (addr_q == rd_rule.address);
  // A rule expiring in the current second still counts as live.
  assign rule_live = rd_rule.enabled && (rd_rule.expiry >= now_q) && rule_hit;
  assign rule_keep = (rd_rule.address != addr_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ipfrt_pkg::S_IDLE: begin
        if (in_fire) begin
          unique case (ipfrt_pkg::op_e'(operation_i))
            ipfrt_pkg::OP_CHECK,
            ipfrt_pkg::OP_REMOVE: state_d = ipfrt_pkg::S_SCAN;
            default:              state_d = ipfrt_pkg::S_DONE;
          endcase
        end
      end
      ipfrt_pkg::S_SCAN: begin
        if (pend_q && (op_q == ipfrt_pkg::OP_CHECK) && rule_live) begin
          state_d = ipfrt_pkg::S_DONE;
        end else if (scan_end) begin
          state_d = ipfrt_pkg::S_DONE;
        end
      end
      ipfrt_pkg::S_DONE: begin
        if (out_free) begin
          state_d = ipfrt_pkg::S_IDLE;
        end
      end
      default: state_d = ipfrt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    op_d         = op_q;
    addr_d       = addr_q;
    now_d        = now_q;
    count_d      = count_q;
    rd_ptr_d     = rd_ptr_q;
    wr_ptr_d     = wr_ptr_q;
    pend_d       = pend_q;
    res_allow_d  = res_allow_q;
    res_match_d  = res_match_q;
    res_status_d = res_status_q;

    out_valid_d   = out_valid_q && !out_ready_i;
    out_allowed_d = out_allowed_q;
    out_matched_d = out_matched_q;
    out_status_d  = out_status_q;
    out_count_d   = out_count_q;

    ram_we    = 1'b0;
    ram_waddr = count_q[IdxW-1:0];
    ram_wdata = '{address: ip_address_i, mask: rule_mask_i, allow: rule_allow_i,
                  enabled: rule_enabled_i, expiry: rule_expires_i};
    ram_re    = 1'b0;
    ram_raddr = rd_ptr_q[IdxW-1:0];

    unique case (state_q)
      ipfrt_pkg::S_IDLE: begin
        if (in_fire) begin
          op_d         = ipfrt_pkg::op_e'(operation_i);
          addr_d       = ip_address_i;
          now_d        = now_seconds_i;
          rd_ptr_d     = '0;
          wr_ptr_d     = '0;
          pend_d       = 1'b0;
          res_allow_d  = 1'b1;
          res_match_d  = 1'b0;
          res_status_d = 1'b0;
          // An add appends behind the held rules in the acceptance cycle itself.
          if (ipfrt_pkg::op_e'(operation_i) == ipfrt_pkg::OP_ADD) begin
            if (table_full) begin
              res_status_d = 1'b1;
            end else begin
              ram_we  = 1'b1;
              count_d = count_q + CntW'(1);
            end
          end
        end
      end
      ipfrt_pkg::S_SCAN: begin
        // Issue the next read while the previous read's data is evaluated.
        if (!scan_end) begin
          ram_re   = 1'b1;
          rd_ptr_d = rd_ptr_q + CntW'(1);
          pend_d   = 1'b1;
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q) begin
          if (op_q == ipfrt_pkg::OP_CHECK) begin
            if (rule_live) begin
              res_allow_d = rd_rule.allow;
              res_match_d = 1'b1;
            end
          end else if (rule_keep) begin
            // Compaction: a kept rule moves down to the write pointer. The write pointer
            // never passes the read pointer, so no write hits an entry still to be read.
            ram_we    = 1'b1;
            ram_waddr = wr_ptr_q[IdxW-1:0];
            ram_wdata = rd_rule;
            wr_ptr_d  = wr_ptr_q + CntW'(1);
          end
        end
        if (scan_end && (op_q == ipfrt_pkg::OP_REMOVE)) begin
          count_d = wr_ptr_q + CntW'(pend_q && rule_keep);
        end
      end
      ipfrt_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_d   = 1'b1;
          out_allowed_d = res_allow_q;
          out_matched_d = res_match_q;
          out_status_d  = res_status_q;
          out_count_d   = ipfrt_pkg::CountW'(count_q);
        end
      end
      default: begin
        pend_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ipfrt_pkg::S_IDLE;
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q          <= op_d;
    addr_q        <= addr_d;
    now_q         <= now_d;
    rd_ptr_q      <= rd_ptr_d;
    wr_ptr_q      <= wr_ptr_d;
    res_allow_q   <= res_allow_d;
    res_match_q   <= res_match_d;
    res_status_q  <= res_status_d;
    out_allowed_q <= out_allowed_d;
    out_matched_q <= out_matched_d;
    out_status_q  <= out_status_d;
    out_count_q   <= out_count_d;
  end

  assign out_valid_o  = out_valid_q;
  assign allowed_o    = out_allowed_q;
  assign matched_o    = out_matched_q;
  assign status_o     = out_status_q;
  assign rule_count_o = out_count_q;

endmodule
